[sv/pnpf_pkg.sv]
package pnpf_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_SCAN_END,
		ST_RD_P1,
		ST_RD_P2,
		ST_BIS_SQ,
		ST_BIS_CMP,
		ST_DIFF,
		ST_SQ,
		ST_ROOT,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic REG_LAST_POINT = 1'b0;
	localparam logic REG_PATH_SPEED = 1'b1;

	localparam logic [30:0] PATH_SPEED_RESET = 31'd6554;

	typedef struct packed {
		logic        we;
		logic        re;
	} mem_ctl_t;

endpackage

[sv/path_nearest_point_follower.sv]
// A waypoint load is taken while idle and busy stays low, so loads can follow back to back.
// A pose query holds busy through the scan, the bisection and, unless the segment has zero
// length, the root and the two divides; the single store read port, the 32-step root and
// the two 64-step divides set how long it lasts.
// The result is on the result ports with done high in the cycle in which busy falls.
// After reset the block clears store slots 0 to MAX_POINTS - 1 with busy high.
module path_nearest_point_follower #(
	parameter int MAX_POINTS = 256,
	parameter int ITERATIONS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [7:0]         point_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [30:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] goal_x,
	output logic signed [31:0] goal_y,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic [7:0]         nearest_point,
	output logic               degenerate
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int IW = $clog2(ITERATIONS + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_POINTS - 1);

	pnpf_pkg::state_t state_q, state_d;

	logic [7:0]        last_idx_q;
	logic [30:0]       speed_q;
	logic [AW-1:0]     near_q;
	logic [AW-1:0]     cnt_q;
	logic [AW-1:0]     scan_end;
	logic [AW-1:0]     nxt;
	logic [IW-1:0]     it_q;
	logic              found_q;
	logic              rd_valid_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic [64:0]       best_q;
	logic signed [31:0] px_q, py_q;
	logic signed [31:0] p1x_q, p1y_q, p2x_q, p2y_q, nx_q, ny_q;
	logic signed [31:0] gx_q, gy_q;
	logic [64:0]       d1_q, d2_q, s_q;
	logic signed [32:0] dx_q, dy_q;
	logic [63:0]       prodx_q, prody_q;
	logic [32:0]       len_q;
	logic              divy_q;
	logic [30:0]       qx_q;
	logic              degen_q;

	pnpf_pkg::mem_ctl_t mctl;
	logic [AW-1:0]     waddr, raddr;
	logic [31:0]       wdx, wdy, rdx, rdy;

	logic              accept;
	logic              sq_go, sq_done, dv_go, dv_done;
	logic [31:0]       sq_root;
	logic [63:0]       dv_quo;
	logic [63:0]       sq_in;
	logic [64:0]       scan_d;
	logic              take;

	function automatic logic [64:0] sqd(input logic signed [32:0] a, input logic signed [32:0] b);
		logic [32:0] ma, mb;
		begin
			ma = a[32] ? 33'(-a) : a;
			mb = b[32] ? 33'(-b) : b;
			sqd = 65'({32'd0, ma[31:0]} * {32'd0, ma[31:0]})
				+ 65'({32'd0, mb[31:0]} * {32'd0, mb[31:0]});
		end
	endfunction

	function automatic logic signed [31:0] mid(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [32:0] s;
		begin
			s = 33'(a) + 33'(b);
			mid = s[32:1];
		end
	endfunction

	function automatic logic signed [31:0] sgn(input logic neg, input logic [30:0] m);
		begin
			sgn = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
		end
	endfunction

	assign accept    = start && !busy;
	assign cfg_ready = (state_q == pnpf_pkg::ST_IDLE);
	assign scan_end  = ({24'd0, last_idx_q} > 32'(MAX_POINTS - 1)) ? LAST_SLOT : AW'(last_idx_q);
	assign nxt       = (near_q == LAST_SLOT) ? '0 : near_q + AW'(1);
	assign sq_in     = s_q[64] ? {2'b01, s_q[63:2]} : s_q[63:0];
	assign scan_d    = sqd(33'($signed(rdx)) - 33'(px_q), 33'($signed(rdy)) - 33'(py_q));
	assign take      = rd_valid_s1 && (rdx != 32'd0 || rdy != 32'd0)
		&& (!found_q || scan_d < best_q);

	pnpf_store #(.AW(AW)) u_store (
		.clk(clk), .ctl(mctl), .waddr(waddr), .wdata_x(wdx), .wdata_y(wdy),
		.raddr(raddr), .rdata_x(rdx), .rdata_y(rdy)
	);

	pnpf_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .go(sq_go), .x(sq_in),
		.done(sq_done), .root(sq_root));

	pnpf_div u_div (.clk(clk), .arst_n(arst_n), .go(dv_go),
		.num((state_q == pnpf_pkg::ST_DIV) ? prody_q : prodx_q), .den(len_q),
		.done(dv_done), .quo(dv_quo));

	always_comb begin
		state_d = state_q;
		case (state_q)
			pnpf_pkg::ST_CLEAR:    if (cnt_q == LAST_SLOT) state_d = pnpf_pkg::ST_IDLE;
			pnpf_pkg::ST_IDLE:
				if (start && mode == pnpf_pkg::MODE_QUERY) state_d = pnpf_pkg::ST_SCAN;
			pnpf_pkg::ST_SCAN:     if (cnt_q == scan_end) state_d = pnpf_pkg::ST_SCAN_END;
			pnpf_pkg::ST_SCAN_END: state_d = pnpf_pkg::ST_RD_P1;
			pnpf_pkg::ST_RD_P1:    state_d = pnpf_pkg::ST_RD_P2;
			pnpf_pkg::ST_RD_P2:    state_d = pnpf_pkg::ST_BIS_SQ;
			pnpf_pkg::ST_BIS_SQ:
				state_d = (it_q == IW'(ITERATIONS)) ? pnpf_pkg::ST_DIFF : pnpf_pkg::ST_BIS_CMP;
			pnpf_pkg::ST_BIS_CMP:  state_d = pnpf_pkg::ST_BIS_SQ;
			pnpf_pkg::ST_DIFF:     state_d = pnpf_pkg::ST_SQ;
			pnpf_pkg::ST_SQ:
				state_d = (s_q == 65'd0) ? pnpf_pkg::ST_EMIT : pnpf_pkg::ST_ROOT;
			pnpf_pkg::ST_ROOT:     if (sq_done) state_d = pnpf_pkg::ST_MUL;
			pnpf_pkg::ST_MUL:      state_d = pnpf_pkg::ST_DIV;
			pnpf_pkg::ST_DIV:      if (dv_done && divy_q) state_d = pnpf_pkg::ST_EMIT;
			pnpf_pkg::ST_EMIT:     state_d = pnpf_pkg::ST_IDLE;
			default:               state_d = pnpf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mctl  = '0;
		waddr = cnt_q;
		wdx   = 32'd0;
		wdy   = 32'd0;
		raddr = cnt_q;
		busy  = (state_q != pnpf_pkg::ST_IDLE);
		sq_go = (state_q == pnpf_pkg::ST_SQ) && (s_q != 65'd0);
		dv_go = (state_q == pnpf_pkg::ST_MUL) || ((state_q == pnpf_pkg::ST_DIV) && dv_done && !divy_q);
		case (state_q)
			pnpf_pkg::ST_CLEAR: mctl.we = 1'b1;
			pnpf_pkg::ST_IDLE: begin
				waddr   = AW'(point_index);
				wdx     = pos_x;
				wdy     = pos_y;
				mctl.we = start && mode == pnpf_pkg::MODE_LOAD
					&& {24'd0, point_index} < 32'(MAX_POINTS);
			end
			pnpf_pkg::ST_SCAN:  mctl.re = 1'b1;
			pnpf_pkg::ST_SCAN_END: begin
				mctl.re = 1'b1;
				raddr   = take ? rd_idx_s1 : near_q;
			end
			pnpf_pkg::ST_RD_P1: begin
				mctl.re = 1'b1;
				raddr   = nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pnpf_pkg::ST_CLEAR;
			cnt_q       <= '0;
			last_idx_q  <= '0;
			speed_q     <= pnpf_pkg::PATH_SPEED_RESET;
			near_q      <= '0;
			found_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			it_q        <= '0;
			divy_q      <= 1'b0;
			done        <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == pnpf_pkg::ST_EMIT);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pnpf_pkg::REG_LAST_POINT) last_idx_q <= cfg_data[7:0];
				else speed_q <= cfg_data;
			end
			rd_valid_s1 <= (state_q == pnpf_pkg::ST_SCAN);
			case (state_q)
				pnpf_pkg::ST_CLEAR: cnt_q <= cnt_q + AW'(1);
				pnpf_pkg::ST_IDLE: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
				end
				pnpf_pkg::ST_SCAN: cnt_q <= cnt_q + AW'(1);
				pnpf_pkg::ST_RD_P2: it_q <= '0;
				pnpf_pkg::ST_BIS_CMP: it_q <= it_q + IW'(1);
				pnpf_pkg::ST_MUL: divy_q <= 1'b0;
				pnpf_pkg::ST_DIV: if (dv_done) divy_q <= 1'b1;
				default: ;
			endcase
			if (take) begin
				found_q <= 1'b1;
				near_q  <= rd_idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (accept) begin
			px_q <= pos_x;
			py_q <= pos_y;
		end
		if (take) begin
			best_q <= scan_d;
		end
		case (state_q)
			pnpf_pkg::ST_RD_P1: begin
				p1x_q <= rdx;
				p1y_q <= rdy;
				gx_q  <= rdx;
				gy_q  <= rdy;
			end
			pnpf_pkg::ST_RD_P2: begin
				p2x_q <= rdx;
				p2y_q <= rdy;
				nx_q  <= rdx;
				ny_q  <= rdy;
			end
			pnpf_pkg::ST_BIS_SQ: begin
				d1_q <= sqd(33'(px_q) - 33'(p1x_q), 33'(py_q) - 33'(p1y_q));
				d2_q <= sqd(33'(px_q) - 33'(p2x_q), 33'(py_q) - 33'(p2y_q));
			end
			pnpf_pkg::ST_BIS_CMP: begin
				gx_q <= mid(p1x_q, p2x_q);
				gy_q <= mid(p1y_q, p2y_q);
				if (d1_q < d2_q) begin
					p2x_q <= mid(p1x_q, p2x_q);
					p2y_q <= mid(p1y_q, p2y_q);
				end else begin
					p1x_q <= mid(p1x_q, p2x_q);
					p1y_q <= mid(p1y_q, p2y_q);
				end
			end
			pnpf_pkg::ST_DIFF: begin
				dx_q <= 33'(nx_q) - 33'(gx_q);
				dy_q <= 33'(ny_q) - 33'(gy_q);
				s_q  <= sqd(33'(nx_q) - 33'(gx_q), 33'(ny_q) - 33'(gy_q));
			end
			pnpf_pkg::ST_SQ: begin
				degen_q <= (s_q == 65'd0);
				prodx_q <= {33'd0, speed_q} * {32'd0, (dx_q[32] ? 32'(-dx_q) : dx_q[31:0])};
				prody_q <= {33'd0, speed_q} * {32'd0, (dy_q[32] ? 32'(-dy_q) : dy_q[31:0])};
			end
			pnpf_pkg::ST_ROOT: begin
				if (sq_done) begin
					len_q <= s_q[64] ? {sq_root, 1'b0}
						: ((sq_root == 32'd0) ? 33'd1 : {1'b0, sq_root});
				end
			end
			pnpf_pkg::ST_DIV: begin
				if (dv_done && !divy_q) begin
					qx_q <= (dv_quo > {33'd0, speed_q}) ? speed_q : dv_quo[30:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == pnpf_pkg::ST_EMIT) begin
			goal_x        <= gx_q;
			goal_y        <= gy_q;
			nearest_point <= 8'(near_q);
			degenerate    <= degen_q;
			if (degen_q) begin
				vel_x <= 32'sd0;
				vel_y <= 32'sd0;
			end else begin
				vel_x <= sgn(dx_q[32], qx_q);
				vel_y <= sgn(!dy_q[32] && dy_q != 33'sd0,
					(dv_quo > {33'd0, speed_q}) ? speed_q : dv_quo[30:0]);
			end
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done lasted more than one cycle");
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pnpf_pkg::ST_EMIT |=> done)
		else $error("result not strobed");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready |-> !busy)
		else $error("config taken while busy");

endmodule

[sv/pnpf_store.sv]
module pnpf_store #(
	parameter int AW = 8
) (
	input  logic                clk,
	input  pnpf_pkg::mem_ctl_t  ctl,
	input  logic [AW-1:0]       waddr,
	input  logic [31:0]         wdata_x,
	input  logic [31:0]         wdata_y,
	input  logic [AW-1:0]       raddr,
	output logic [31:0]         rdata_x,
	output logic [31:0]         rdata_y
);

	logic [63:0] mem [0:(1 << AW)-1];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= {wdata_x, wdata_y};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			{rdata_x, rdata_y} <= mem[raddr];
		end
	end

endmodule

[sv/pnpf_sqrt.sv]
module pnpf_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] op_q;
	logic [63:0] res_q;
	logic [63:0] one_q;
	logic        run_q;
	logic [64:0] trial;

	assign trial = {1'b0, res_q} + {1'b0, one_q};
	assign done  = run_q && (one_q == 64'd0);
	assign root  = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (go) begin
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			op_q  <= x;
			res_q <= 64'd0;
			one_q <= 64'h4000_0000_0000_0000;
		end else if (run_q && one_q != 64'd0) begin
			if ({1'b0, op_q} >= trial) begin
				op_q  <= op_q - trial[63:0];
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

endmodule

[sv/pnpf_div.sv]
module pnpf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [63:0] quo
);

	logic [63:0] q_q;
	logic [33:0] r_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic [34:0] shifted;
	logic [34:0] diff;

	assign shifted = {r_q, q_q[63]};
	assign diff    = shifted - {2'b00, den};
	assign done    = run_q && (cnt_q == 7'd64);
	assign quo     = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= '0;
		end else if (run_q && cnt_q != 7'd64) begin
			if (!diff[34]) begin
				r_q <= diff[33:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= shifted[33:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

endmodule

[bench/path_nearest_point_follower_checker.sv]
module path_nearest_point_follower_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               mode,
	input  logic [7:0]         point_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               done,
	input  logic signed [31:0] goal_x,
	input  logic signed [31:0] goal_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic [7:0]         nearest_point,
	input  logic               degenerate,
	output int                 pending,
	output int                 errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] gx;
		logic [31:0] gy;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [7:0]  np;
		logic        dg;
	} guidance_t;

	logic signed [31:0] wp_x [256];
	logic signed [31:0] wp_y [256];
	logic [7:0]  nearest_idx;
	logic [7:0]  scan_last;
	logic [63:0] speed;
	guidance_t   guidance_q[$];

	function automatic logic [63:0] mag(input logic signed [32:0] d);
		logic signed [32:0] m;
		m = d < 0 ? -d : d;
		return {31'd0, m};
	endfunction

	function automatic logic [64:0] sq_dist(input logic signed [32:0] dx,
			input logic signed [32:0] dy);
		logic [63:0] sa, sb, s;
		sa = mag(dx) * mag(dx);
		sb = mag(dy) * mag(dy);
		s = sa + sb;
		return {(s < sa), s};
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] op, res, one;
		op = x;
		res = 0;
		one = 64'd1 << 62;
		while (one > op)
			one = one >> 2;
		while (one != 0) begin
			if (op >= res + one) begin
				op = op - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] speed_term(input logic signed [32:0] d,
			input logic [63:0] len);
		logic [63:0] q;
		q = (speed * mag(d)) / len;
		if (q > speed)
			q = speed;
		return d < 0 ? -q[31:0] : q[31:0];
	endfunction

	function automatic logic [31:0] midpoint(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		s = s >>> 1;
		return s[31:0];
	endfunction

	task automatic predict_guidance(input logic signed [31:0] px,
			input logic signed [31:0] py);
		guidance_t g;
		logic found;
		logic [64:0] best, d, d2;
		logic [7:0] nxt;
		logic signed [31:0] p1x, p1y, p2x, p2y, gx, gy;
		logic signed [32:0] dx, dy;
		logic [63:0] len;
		found = 0;
		best = 0;
		for (int i = 0; i <= scan_last; i++) begin
			if (wp_x[i] != 0 || wp_y[i] != 0) begin
				d = sq_dist(33'(wp_x[i]) - 33'(px), 33'(wp_y[i]) - 33'(py));
				if (!found || d < best) begin
					found = 1;
					best = d;
					nearest_idx = 8'(i);
				end
			end
		end
		nxt = nearest_idx + 8'd1;
		p1x = wp_x[nearest_idx];
		p1y = wp_y[nearest_idx];
		p2x = wp_x[nxt];
		p2y = wp_y[nxt];
		gx = p1x;
		gy = p1y;
		for (int it = 0; it < 10; it++) begin
			d = sq_dist(33'(px) - 33'(p1x), 33'(py) - 33'(p1y));
			d2 = sq_dist(33'(px) - 33'(p2x), 33'(py) - 33'(p2y));
			gx = midpoint(p1x, p2x);
			gy = midpoint(p1y, p2y);
			if (d < d2) begin
				p2x = gx;
				p2y = gy;
			end else begin
				p1x = gx;
				p1y = gy;
			end
		end
		dx = 33'(wp_x[nxt]) - 33'(gx);
		dy = 33'(wp_y[nxt]) - 33'(gy);
		d = sq_dist(dx, dy);
		g.gx = gx;
		g.gy = gy;
		g.np = nearest_idx;
		g.vx = 0;
		g.vy = 0;
		g.dg = 0;
		if (d == 0) begin
			g.dg = 1;
		end else begin
			if (!d[64])
				len = int_sqrt(d[63:0]);
			else
				len = 2 * int_sqrt({2'b01, d[63:2]});
			if (len == 0)
				len = 1;
			g.vx = speed_term(dx, len);
			g.vy = speed_term(-dy, len);
		end
		guidance_q = {guidance_q, g};
	endtask

	always @(posedge clk or negedge arst_n) begin
		guidance_t e;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) begin
				wp_x[i] = 0;
				wp_y[i] = 0;
			end
			nearest_idx = 0;
			scan_last = 0;
			speed = 64'(pnpf_pkg::PATH_SPEED_RESET);
			guidance_q.delete();
			errors = 0;
		end else begin
			if (done) begin
				if (guidance_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: goal %h %h", goal_x, goal_y);
				end else begin
					e = guidance_q.pop_front();
					if (e.gx !== goal_x || e.gy !== goal_y || e.vx !== vel_x ||
							e.vy !== vel_y || e.np !== nearest_point ||
							e.dg !== degenerate) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %h %h %h %h %0d %b, got %h %h %h %h %0d %b",
								e.gx, e.gy, e.vx, e.vy, e.np, e.dg,
								goal_x, goal_y, vel_x, vel_y, nearest_point, degenerate);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pnpf_pkg::REG_LAST_POINT)
					scan_last = cfg_data[7:0];
				else
					speed = 64'(cfg_data);
			end
			if (start && !busy) begin
				if (mode == pnpf_pkg::MODE_LOAD) begin
					wp_x[point_index] = pos_x;
					wp_y[point_index] = pos_y;
				end else begin
					predict_guidance(pos_x, pos_y);
				end
			end
		end
		pending = guidance_q.size();
	end

endmodule

[bench/path_nearest_point_follower_tb.sv]
module path_nearest_point_follower_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic               mode = pnpf_pkg::MODE_LOAD;
	logic [7:0]         point_index = 0;
	logic signed [31:0] pos_x = 0;
	logic signed [31:0] pos_y = 0;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic               cfg_index = pnpf_pkg::REG_LAST_POINT;
	logic [30:0]        cfg_data = 0;
	logic               done;
	logic signed [31:0] goal_x, goal_y, vel_x, vel_y;
	logic [7:0]         nearest_point;
	logic               degenerate;
	int                 pending, errors;
	int                 cycles = 0;
	int                 idle_pct = 0;
	logic [7:0]         prev_slot = 0;
	logic [31:0]        prev_x = 1, prev_y = 1;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	path_nearest_point_follower uut (.*);

	path_nearest_point_follower_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_item(input logic m, input logic [7:0] idx,
			input logic [31:0] x, input logic [31:0] y);
		logic acc;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1;
		mode <= m;
		point_index <= idx;
		pos_x <= x;
		pos_y <= y;
		if (m == pnpf_pkg::MODE_LOAD) begin
			prev_slot = idx;
			prev_x = x;
			prev_y = y;
		end
		do begin
			@(negedge clk);
			acc = !busy;
			@(posedge clk);
		end while (!acc);
	endtask

	task automatic settle();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [30:0] data);
		logic acc;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 9) < 4)
			return $urandom;
		return 32'($signed($urandom_range(0, 2097151)) - 1048576);
	endfunction

	initial begin
		int lim;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		settle();
		// An empty store keeps the reset nearest index.
		send_item(pnpf_pkg::MODE_QUERY, 8'd0, 32'h7fffffff, 32'h80000000);
		settle();
		write_reg(pnpf_pkg::REG_LAST_POINT, 31'd255);
		write_reg(pnpf_pkg::REG_PATH_SPEED, 31'h7fffffff);
		send_item(pnpf_pkg::MODE_LOAD, 8'd255, 32'h7fffffff, 32'h80000000);
		send_item(pnpf_pkg::MODE_QUERY, 8'd0, 32'h7fffffff, 32'h80000000);
		send_item(pnpf_pkg::MODE_LOAD, 8'd0, 32'h80000000, 32'h7fffffff);
		send_item(pnpf_pkg::MODE_QUERY, 8'd0, 32'h7fff0000, 32'h80010000);
		send_item(pnpf_pkg::MODE_QUERY, 8'd0, 32'h80000000, 32'h80000000);
		send_item(pnpf_pkg::MODE_LOAD, 8'd3, 32'h00050000, 32'hfffb0000);
		send_item(pnpf_pkg::MODE_LOAD, 8'd4, 32'h00050000, 32'hfffb0000);
		send_item(pnpf_pkg::MODE_QUERY, 8'd0, 32'h00050001, 32'hfffb0001);
		send_item(pnpf_pkg::MODE_LOAD, 8'd5, 32'h00000000, 32'h00000001);
		send_item(pnpf_pkg::MODE_LOAD, 8'd6, 32'hffffffff, 32'h00000000);
		send_item(pnpf_pkg::MODE_QUERY, 8'd0, 32'h00000000, 32'h00000000);
		send_item(pnpf_pkg::MODE_QUERY, 8'd0, 32'hffffffff, 32'hffffffff);
		settle();
		write_reg(pnpf_pkg::REG_PATH_SPEED, 31'd0);
		send_item(pnpf_pkg::MODE_QUERY, 8'd0, 32'h00010000, 32'h00010000);
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = ph == 0 ? 10 : (ph == 1 ? 76 : 0);
			for (int sg = 0; sg < 4; sg++) begin
				settle();
				case (sg)
					0: lim = 0;
					1: lim = 255;
					2: lim = $urandom_range(1, 15);
					default: lim = $urandom_range(1, 60);
				endcase
				write_reg(pnpf_pkg::REG_LAST_POINT, 31'(lim));
				case ($urandom_range(0, 3))
					0: write_reg(pnpf_pkg::REG_PATH_SPEED, 31'd0);
					1: write_reg(pnpf_pkg::REG_PATH_SPEED, 31'h7fffffff);
					2: write_reg(pnpf_pkg::REG_PATH_SPEED, pnpf_pkg::PATH_SPEED_RESET);
					default: write_reg(pnpf_pkg::REG_PATH_SPEED, 31'($urandom));
				endcase
				for (int n = 0; n < 140; n++) begin
					int r;
					r = $urandom_range(0, 99);
					if (r < 8)
						send_item(pnpf_pkg::MODE_LOAD, prev_slot + 8'd1, prev_x, prev_y);
					else if (r < 14)
						send_item(pnpf_pkg::MODE_LOAD,
							8'($urandom_range(0, lim < 255 ? lim + 1 : 255)), 32'd0, 32'd0);
					else if (r < 52)
						send_item(pnpf_pkg::MODE_LOAD,
							8'($urandom_range(0, lim < 255 ? lim + 1 : 255)),
							rand_coord(), rand_coord());
					else if (r < 55)
						send_item(pnpf_pkg::MODE_LOAD, 8'($urandom), $urandom, $urandom);
					else
						send_item(pnpf_pkg::MODE_QUERY, 8'($urandom), rand_coord(), rand_coord());
				end
			end
		end
		settle();
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
sv/pnpf_pkg.sv
sv/pnpf_store.sv
sv/pnpf_sqrt.sv
sv/pnpf_div.sv
sv/path_nearest_point_follower.sv
bench/path_nearest_point_follower_checker.sv
bench/path_nearest_point_follower_tb.sv
